@@ hdl/qts_pkg.sv @@
// ----------------------------------------------------------------------------
// qts_pkg
// Types and constants shared by the quoted token splitter files.
// ----------------------------------------------------------------------------
package qts_pkg;

   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned OUT_LEN_W   = 16;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_NUL       = 8'h00;

   localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_USE_DELIM_SET = 3'd0,
      REG_DELIM_MAP_0   = 3'd1,
      REG_DELIM_MAP_1   = 3'd2,
      REG_DELIM_MAP_2   = 3'd3,
      REG_DELIM_MAP_3   = 3'd4,
      REG_MAX_TOKEN_LEN = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_NORMAL     = 2'd0,
      MODE_QUOTED     = 2'd1,
      MODE_NORMAL_ESC = 2'd2,
      MODE_QUOTED_ESC = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE     = 2'd0,
      KIND_END      = 2'd1,
      KIND_OVERFLOW = 2'd2,
      KIND_UNCLOSED = 2'd3
   } kind_type;

   // Register file contents as seen by the parser.
   typedef struct packed {
      logic         use_delim_set;
      logic [255:0] delim_map;       // bit b marks byte value b as a delimiter
      logic [15:0]  max_token_len;
   } csr_type;

endpackage

@@ hdl/qts_if.sv @@
// ----------------------------------------------------------------------------
// qts_req_if / qts_rsp_if
// Valid/ready channels for input bytes and for result items.
// ----------------------------------------------------------------------------
interface qts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface qts_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  char_byte;
   logic [15:0] token_length;
   logic        quote_single;

   modport source (output valid, output kind, output char_byte, output token_length,
                   output quote_single, input ready);
   modport sink   (input valid, input kind, input char_byte, input token_length,
                   input quote_single, output ready);
endinterface

@@ hdl/qts_csr_regs.sv @@
// ----------------------------------------------------------------------------
// qts_csr_regs
// Write-only configuration registers: delimiter mode, delimiter map, length limit.
// ----------------------------------------------------------------------------
module qts_csr_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [qts_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [qts_pkg::CSR_DATA_W-1:0]       csr_write_data,
   output qts_pkg::csr_type                     csr
);
   import qts_pkg::*;

   csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_USE_DELIM_SET: csr_in.use_delim_set = csr_write_data[0];
            REG_DELIM_MAP_0:   csr_in.delim_map[63:0]    = csr_write_data;
            REG_DELIM_MAP_1:   csr_in.delim_map[127:64]  = csr_write_data;
            REG_DELIM_MAP_2:   csr_in.delim_map[191:128] = csr_write_data;
            REG_DELIM_MAP_3:   csr_in.delim_map[255:192] = csr_write_data;
            REG_MAX_TOKEN_LEN: csr_in.max_token_len = csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.use_delim_set <= 1'b0;
         csr_ff.delim_map     <= '0;
         csr_ff.max_token_len <= MAX_LEN_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

@@ hdl/qts_parse.sv @@
// ----------------------------------------------------------------------------
// qts_parse
// Per-byte tokenizer state machine and the result register.
// ----------------------------------------------------------------------------
module qts_parse #(
   parameter int unsigned LEN_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [7:0]       in_byte,
   input  logic             end_of_input,
   input  qts_pkg::csr_type csr,
   qts_rsp_if.source        rsp
);
   import qts_pkg::*;

   localparam int unsigned CW = (LEN_BITS > OUT_LEN_W) ? LEN_BITS : OUT_LEN_W;

   mode_type            mode_ff, mode_in;
   logic                oq_single_ff, oq_single_in;
   logic [LEN_BITS-1:0] count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [7:0]          char_ff, char_in;
   logic [15:0]         len_ff, len_in;
   logic                qs_ff, qs_in;

   logic                emit;
   logic                keep;
   logic                quoted;
   logic                is_delim;
   logic [LEN_BITS-1:0] next_count;
   logic [CW-1:0]       count_ext;
   logic [CW-1:0]       next_ext;
   logic [CW-1:0]       max_ext;
   logic                overflow;

   always_comb begin
      if (csr.use_delim_set) begin
         is_delim = (in_byte == CH_NUL) || csr.delim_map[in_byte];
      end else begin
         is_delim = (in_byte == CH_SPACE) || (in_byte inside {[8'd9:8'd13]});
      end
   end

   // counter saturates rather than wrapping to zero
   assign next_count = (&count_ff) ? count_ff : count_ff + 1'b1;
   assign count_ext  = CW'(count_ff);
   assign next_ext   = CW'(next_count);
   assign max_ext    = CW'(csr.max_token_len);
   assign overflow   = (next_ext >= max_ext) || (&next_count);
   assign quoted     = (mode_ff == MODE_QUOTED) || (mode_ff == MODE_QUOTED_ESC);

   always_comb begin
      mode_in      = mode_ff;
      oq_single_in = oq_single_ff;
      count_in     = count_ff;
      emit         = 1'b0;
      keep         = 1'b0;
      kind_in      = KIND_BYTE;
      char_in      = 8'd0;
      len_in       = count_ext[15:0];
      qs_in        = 1'b0;

      if (fire) begin
         if (end_of_input) begin
            emit         = 1'b1;
            kind_in      = quoted ? KIND_UNCLOSED : KIND_END;
            qs_in        = quoted & oq_single_ff;
            mode_in      = MODE_NORMAL;
            oq_single_in = 1'b0;
            count_in     = '0;
         end else begin
            case (mode_ff)
               MODE_NORMAL_ESC: begin
                  mode_in = MODE_NORMAL;
                  keep    = 1'b1;
               end
               MODE_QUOTED_ESC: begin
                  mode_in = MODE_QUOTED;
                  keep    = 1'b1;
               end
               MODE_QUOTED: begin
                  if (in_byte == CH_BACKSLASH) begin
                     mode_in = MODE_QUOTED_ESC;
                  end else if (in_byte == (oq_single_ff ? CH_SQUOTE : CH_DQUOTE)) begin
                     mode_in = MODE_NORMAL;
                  end else begin
                     keep = 1'b1;
                  end
               end
               default: begin
                  if (is_delim) begin
                     emit     = 1'b1;
                     kind_in  = KIND_END;
                     count_in = '0;
                  end else if (in_byte == CH_BACKSLASH) begin
                     mode_in = MODE_NORMAL_ESC;
                  end else if (in_byte == CH_SQUOTE || in_byte == CH_DQUOTE) begin
                     mode_in      = MODE_QUOTED;
                     oq_single_in = (in_byte == CH_SQUOTE);
                  end else begin
                     keep = 1'b1;
                  end
               end
            endcase

            if (keep) begin
               emit    = 1'b1;
               char_in = in_byte;
               len_in  = next_ext[15:0];
               if (overflow) begin
                  kind_in      = KIND_OVERFLOW;
                  mode_in      = MODE_NORMAL;
                  oq_single_in = 1'b0;
                  count_in     = '0;
               end else begin
                  kind_in  = KIND_BYTE;
                  count_in = next_count;
               end
            end
         end
      end

      // fire is only raised when the result register is free
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         oq_single_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         oq_single_ff <= oq_single_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         len_ff  <= len_in;
         qs_ff   <= qs_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = kind_ff;
   assign rsp.char_byte    = char_ff;
   assign rsp.token_length = len_ff;
   assign rsp.quote_single = qs_ff;

endmodule

@@ hdl/quoted_token_splitter_core.sv @@
// ----------------------------------------------------------------------------
// quoted_token_splitter_core
// Splits a byte stream into tokens with quoting and backslash escapes.
// ----------------------------------------------------------------------------
// Result: the accepted byte waits in the input register, then parse logic
//   writes the result register once that register is free.
// Throughput: 1 request per cycle while the result register is not stalled;
//   the per-byte parser state update is the loop that sets this rate.
// Reset: synchronous; parser returns to normal mode with an empty token,
//   registers return to whitespace delimiters and a 4096-byte limit.
module quoted_token_splitter_core #(
   parameter int unsigned LEN_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   qts_req_if.sink                           req_ch,
   qts_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [qts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [qts_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import qts_pkg::*;

   csr_type    csr;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eoi_ff;
   logic       out_free;
   logic       fire;
   logic       req_take;

   assign out_free     = !rsp_ch.valid || rsp_ch.ready;
   assign fire         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.in_byte;
         in_eoi_ff  <= req_ch.end_of_input;
      end
   end

   qts_csr_regs u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   qts_parse #(
      .LEN_BITS (LEN_BITS)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .in_byte      (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .csr          (csr),
      .rsp          (rsp_ch)
   );

endmodule
